@@ src/msd_pkg.sv @@
// Shared types, constants and helper functions for the MFM sync track decoder.
// Used by every module of the decoder and by msd_out_if; depends on nothing else.
package msd_pkg;

    // Field widths of the input and result transactions.
    localparam int DATA_W   = 32;
    localparam int INDEX_W  = 12;
    localparam int STATUS_W = 2;
    localparam int OFFS_W   = 32;

    // Configuration port.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_PATTERN = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TRACK_WORDS  = 1'b1;

    // Track configuration.
    localparam int SYNC_W        = 16;
    localparam int TRACK_WORDS_W = 13;
    localparam int MAX_TRACK_WORDS = 4096;
    localparam logic [SYNC_W-1:0] SYNC_RESET = 16'h8915;
    localparam logic [TRACK_WORDS_W-1:0] TRACK_WORDS_RESET = TRACK_WORDS_W'(11 * 512 / 4);

    // Raw shift register and per-long cell counter.
    localparam int RAW_W  = 64;
    localparam int CELL_W = 6;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_DATA      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_GOOD      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD       = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

    // Result queue between the front and the back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Mask that keeps the data cells of a raw MFM word.
    localparam logic [DATA_W-1:0] DATA_MASK = 32'h5555_5555;

    // One result transaction.
    typedef struct packed {
        logic [DATA_W-1:0]   data_word;
        logic [INDEX_W-1:0]  word_index;
        logic                last;
        logic [STATUS_W-1:0] status;
        logic [OFFS_W-1:0]   sync_offset;
    } t_result;

    // Decodes 64 raw bits into one long: the odd half then the even half.
    function automatic logic [DATA_W-1:0] f_decode_long(input logic [RAW_W-1:0] raw);
        logic [DATA_W-1:0] odd;
        logic [DATA_W-1:0] even;
        odd  = raw[RAW_W-1:DATA_W] & DATA_MASK;
        even = raw[DATA_W-1:0] & DATA_MASK;
        return (odd << 1) | even;
    endfunction

endpackage

@@ src/msd_in_if.sv @@
// Input channel of the MFM sync track decoder: one raw bit or end of stream.
// Depends on nothing else.
interface msd_in_if;
    logic valid;
    logic ready;
    logic kind;
    logic raw_bit;

    modport source (output valid, output kind, output raw_bit, input ready);
    modport sink   (input valid, input kind, input raw_bit, output ready);
endinterface

@@ src/msd_out_if.sv @@
// Result channel of the MFM sync track decoder: decoded longs and track status.
// Depends on msd_pkg for the field widths.
interface msd_out_if
    import msd_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [DATA_W-1:0]   data_word;
    logic [INDEX_W-1:0]  word_index;
    logic                last;
    logic [STATUS_W-1:0] status;
    logic [OFFS_W-1:0]   sync_offset;

    modport source (output valid, output data_word, output word_index, output last,
                    output status, output sync_offset, input ready);
    modport sink   (input valid, input data_word, input word_index, input last,
                    input status, input sync_offset, output ready);
endinterface

@@ src/msd_front.sv @@
// Front end of the decoder: accepts raw bits, hunts for sync, decodes longs,
// keeps the checksum and pushes result records into the queue. Depends on msd_pkg.
module msd_front
    import msd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_accept,
    input  logic                  i_kind,
    input  logic                  i_raw_bit,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                  o_push,
    output t_result               o_result
);

    // Track phases.
    localparam logic [1:0] PH_HUNT = 2'd0;
    localparam logic [1:0] PH_CSUM = 2'd1;
    localparam logic [1:0] PH_DATA = 2'd2;
    localparam logic [1:0] PH_IDLE = 2'd3;

    logic [SYNC_W-1:0]        r_sync_pattern;
    logic [TRACK_WORDS_W-1:0] r_track_words;

    logic [RAW_W-1:0]   r_raw_shift, n_raw_shift;
    logic [1:0]         r_phase, n_phase;
    logic [CELL_W-1:0]  r_cell_count, n_cell_count;
    logic [INDEX_W-1:0] r_word_count, n_word_count;
    logic [DATA_W-1:0]  r_sum, n_sum;
    logic [OFFS_W-1:0]  r_bit_pos, n_bit_pos;
    logic [OFFS_W-1:0]  r_found_off, n_found_off;

    logic [TRACK_WORDS_W-1:0] eff_words;
    logic [DATA_W-1:0]        long_val;
    logic [CELL_W-1:0]        cell_inc;
    logic [TRACK_WORDS_W-1:0] word_next;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_pattern <= SYNC_RESET;
            r_track_words  <= TRACK_WORDS_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SYNC_PATTERN: r_sync_pattern <= i_cfg_data[SYNC_W-1:0];
                CFG_TRACK_WORDS:  r_track_words  <= i_cfg_data[TRACK_WORDS_W-1:0];
                default: ;
            endcase
        end
    end

    // Track length clamped to the supported range.
    always_comb begin
        if (r_track_words == '0) begin
            eff_words = TRACK_WORDS_W'(1);
        end else if (r_track_words > TRACK_WORDS_W'(MAX_TRACK_WORDS)) begin
            eff_words = TRACK_WORDS_W'(MAX_TRACK_WORDS);
        end else begin
            eff_words = r_track_words;
        end
    end

    // Next state and result record for one accepted transaction.
    always_comb begin
        n_raw_shift  = r_raw_shift;
        n_phase      = r_phase;
        n_cell_count = r_cell_count;
        n_word_count = r_word_count;
        n_sum        = r_sum;
        n_bit_pos    = r_bit_pos;
        n_found_off  = r_found_off;
        o_push       = 1'b0;
        o_result     = '0;
        cell_inc     = r_cell_count + CELL_W'(1);
        word_next    = {1'b0, r_word_count} + TRACK_WORDS_W'(1);
        long_val     = '0;

        if (i_accept) begin
            if (i_kind) begin
                // End of stream: report not found unless a track already passed.
                n_raw_shift  = '0;
                n_phase      = PH_HUNT;
                n_cell_count = '0;
                n_word_count = '0;
                n_sum        = '0;
                n_bit_pos    = '0;
                n_found_off  = '0;
                if (r_phase != PH_IDLE) begin
                    o_push            = 1'b1;
                    o_result.last     = 1'b1;
                    o_result.status   = ST_NOT_FOUND;
                end
            end else begin
                n_bit_pos   = r_bit_pos + OFFS_W'(1);
                n_raw_shift = {r_raw_shift[RAW_W-2:0], i_raw_bit};
                long_val    = f_decode_long(n_raw_shift);
                case (r_phase)
                    PH_HUNT: begin
                        if (n_raw_shift[SYNC_W-1:0] == r_sync_pattern) begin
                            n_found_off  = r_bit_pos - OFFS_W'(15);
                            n_phase      = PH_CSUM;
                            n_cell_count = '0;
                            n_word_count = '0;
                        end
                    end
                    PH_CSUM: begin
                        n_cell_count = cell_inc;
                        if (cell_inc == '0) begin
                            n_sum   = long_val;
                            n_phase = PH_DATA;
                        end
                    end
                    PH_DATA: begin
                        n_cell_count = cell_inc;
                        if (cell_inc == '0) begin
                            n_sum                = r_sum - long_val;
                            o_push               = 1'b1;
                            o_result.data_word   = long_val;
                            o_result.word_index  = r_word_count;
                            o_result.sync_offset = r_found_off;
                            if (word_next >= eff_words) begin
                                o_result.last   = 1'b1;
                                o_result.status = (n_sum == '0) ? ST_GOOD : ST_BAD;
                                n_phase         = (n_sum == '0) ? PH_IDLE : PH_HUNT;
                                n_word_count    = '0;
                            end else begin
                                o_result.status = ST_DATA;
                                n_word_count    = word_next[INDEX_W-1:0];
                            end
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_raw_shift  <= '0;
            r_phase      <= PH_HUNT;
            r_cell_count <= '0;
            r_word_count <= '0;
            r_sum        <= '0;
            r_bit_pos    <= '0;
            r_found_off  <= '0;
        end else begin
            r_raw_shift  <= n_raw_shift;
            r_phase      <= n_phase;
            r_cell_count <= n_cell_count;
            r_word_count <= n_word_count;
            r_sum        <= n_sum;
            r_bit_pos    <= n_bit_pos;
            r_found_off  <= n_found_off;
        end
    end

endmodule

@@ src/msd_queue.sv @@
// Short result queue between the decoder front end and the output stage.
// Depends on msd_pkg for the result record and the queue depth.
module msd_queue
    import msd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_result,
    input  logic    i_pop,
    output logic    o_full,
    output logic    o_valid,
    output t_result o_result
);

    t_result           r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    logic do_push;
    logic do_pop;

    assign o_full   = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_valid  = (r_count != '0);
    assign o_result = r_mem[r_rd_ptr];
    assign do_push  = i_push && !o_full;
    assign do_pop   = i_pop && o_valid;

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_result;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + QCNT_W'(1);
                2'b01:   r_count <= r_count - QCNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

@@ src/msd_back.sv @@
// Output stage of the decoder: takes records from the queue into a register
// and presents them on the result channel. Depends on msd_pkg and msd_out_if.
module msd_back
    import msd_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_valid,
    input  t_result          i_q_result,
    output logic             o_q_pop,
    msd_out_if.source        o_result
);

    logic    r_valid;
    t_result r_res;

    // Load a new record when the register is empty or being taken.
    assign o_q_pop = i_q_valid && (!r_valid || o_result.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_q_pop) begin
            r_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_res <= i_q_result;
        end
    end

    // Drive the result channel.
    assign o_result.valid       = r_valid;
    assign o_result.data_word   = r_res.data_word;
    assign o_result.word_index  = r_res.word_index;
    assign o_result.last        = r_res.last;
    assign o_result.status      = r_res.status;
    assign o_result.sync_offset = r_res.sync_offset;

endmodule

@@ src/mfm_sync_track_decoder_core.sv @@
// Top level of the MFM sync track decoder: front end, result queue and output stage.
// Depends on msd_pkg, msd_in_if, msd_out_if, msd_front, msd_queue and msd_back.

// The decoder takes one transaction per clock cycle while the queue has room: a raw
// MFM bit or an end of stream marker. After the sync word it gathers 64 raw bits per
// long (odd cells first, then even cells); the first long is the checksum, and each
// data long after it leaves as one result transaction, the last one carrying the
// checksum verdict. End of stream gives one not-found result unless a track has
// already passed, and restarts the decoder. A four-entry result queue and an output
// register sit between the bit front end and the result channel, so a stalled result
// side only holds off input once the queue is full; otherwise every offered item is
// accepted, and each result is held in a queue entry, then in the output register.
// Configuration is written through i_cfg_we, i_cfg_idx and i_cfg_data; the user
// must write it only while the decoder is idle, which the decoder does not enforce.
module mfm_sync_track_decoder_core
    import msd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    msd_in_if.sink                i_item,
    msd_out_if.source             o_result
);

    logic    accept;
    logic    push;
    t_result push_res;
    logic    q_full;
    logic    q_valid;
    t_result q_res;
    logic    q_pop;

    // Input is taken whenever the queue has room for a possible result.
    assign i_item.ready = !q_full;
    assign accept       = i_item.valid && !q_full;

    msd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_kind     (i_item.kind),
        .i_raw_bit  (i_item.raw_bit),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_push     (push),
        .o_result   (push_res)
    );

    msd_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_result (push_res),
        .i_pop    (q_pop),
        .o_full   (q_full),
        .o_valid  (q_valid),
        .o_result (q_res)
    );

    msd_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (q_valid),
        .i_q_result (q_res),
        .o_q_pop    (q_pop),
        .o_result   (o_result)
    );

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for mfm_sync_track_decoder_core: random raw MFM bit streams
// go in, decoded longs and track verdicts are checked against an in-bench track decoder.
// Depends on msd_pkg, msd_in_if, msd_out_if and the decoder RTL.
module testbench;
    import msd_pkg::*;

    localparam logic KIND_BIT = 1'b0;
    localparam logic KIND_EOS = 1'b1;

    localparam int TOTAL_ITEMS   = 1850;
    localparam int LONG_HOLD     = 400;
    localparam int SETTLE_CYCLES = 16;
    localparam int STALL_LIMIT   = 5000;

    typedef struct packed {
        logic kind;
        logic raw_bit;
    } stream_item_t;

    typedef enum logic [1:0] {
        TRK_HUNT,
        TRK_CHECKSUM,
        TRK_DATA,
        TRK_IDLE
    } track_phase_e;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic                  cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx  = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    logic drv_valid  = 1'b0;
    logic drv_kind   = 1'b0;
    logic drv_bit    = 1'b0;
    logic sink_ready = 1'b0;

    msd_in_if  in_if ();
    msd_out_if out_if ();

    assign in_if.valid   = drv_valid;
    assign in_if.kind    = drv_kind;
    assign in_if.raw_bit = drv_bit;
    assign out_if.ready  = sink_ready;

    mfm_sync_track_decoder_core uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_item     (in_if),
        .o_result   (out_if)
    );

    // Stimulus and expected results.
    stream_item_t bit_stream_q[$];
    t_result      expected_track_results[$];

    int items_pushed    = 0;
    int items_taken     = 0;
    int results_checked = 0;
    int mismatches      = 0;

    // Handshake flags seen at the last rising edge, used by the falling-edge drivers.
    logic in_taken  = 1'b0;
    logic out_taken = 1'b0;

    // Sender and receiver pacing.
    int src_wait     = 0;
    bit src_calm     = 1'b0;
    bit src_nogap    = 1'b0;
    int sink_wait    = 0;
    bit sink_calm    = 1'b0;
    int hold_requests = 0;
    int hold_served   = 0;

    // Register copies and decoder state of the bench-side track decoder.
    logic [SYNC_W-1:0]        cfg_sync_copy  = SYNC_RESET;
    logic [TRACK_WORDS_W-1:0] cfg_words_copy = TRACK_WORDS_RESET;
    logic [RAW_W-1:0]         rx_shift   = '0;
    track_phase_e             trk_phase  = TRK_HUNT;
    logic [CELL_W-1:0]        cell_cnt   = '0;
    logic [INDEX_W-1:0]       long_cnt   = '0;
    logic [DATA_W-1:0]        csum_left  = '0;
    logic [OFFS_W-1:0]        stream_pos = '0;
    logic [OFFS_W-1:0]        sync_pos   = '0;

    // Clock.
    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Gathers the data cells of 64 raw bits: odd cells from the first half, even from the second.
    function automatic logic [DATA_W-1:0] unpack_long(input logic [RAW_W-1:0] raw);
        logic [DATA_W-1:0] data;
        for (int k = 0; k < 16; k++) begin
            data[2*k+1] = raw[2*k+32];
            data[2*k]   = raw[2*k];
        end
        return data;
    endfunction

    // Advances the bench-side decoder by one input transaction and queues any result.
    task automatic track_decode_step(input stream_item_t it);
        logic [OFFS_W-1:0] pos;
        logic [DATA_W-1:0] val;
        int                limit;
        t_result           r;
        r = '0;
        if (it.kind == KIND_EOS) begin
            if (trk_phase != TRK_IDLE) begin
                r.last   = 1'b1;
                r.status = ST_NOT_FOUND;
                expected_track_results.push_back(r);
            end
            rx_shift   = '0;
            trk_phase  = TRK_HUNT;
            cell_cnt   = '0;
            long_cnt   = '0;
            csum_left  = '0;
            stream_pos = '0;
            sync_pos   = '0;
        end else begin
            pos        = stream_pos;
            stream_pos = stream_pos + 1;
            rx_shift   = {rx_shift[RAW_W-2:0], it.raw_bit};
            case (trk_phase)
                TRK_HUNT: begin
                    if (rx_shift[SYNC_W-1:0] == cfg_sync_copy) begin
                        sync_pos  = pos - 15;
                        trk_phase = TRK_CHECKSUM;
                        cell_cnt  = '0;
                        long_cnt  = '0;
                    end
                end
                TRK_CHECKSUM: begin
                    cell_cnt = cell_cnt + CELL_W'(1);
                    if (cell_cnt == 0) begin
                        csum_left = unpack_long(rx_shift);
                        trk_phase = TRK_DATA;
                    end
                end
                TRK_DATA: begin
                    cell_cnt = cell_cnt + CELL_W'(1);
                    if (cell_cnt == 0) begin
                        val       = unpack_long(rx_shift);
                        csum_left = csum_left - val;
                        // A zero length counts as one long, and the length is capped.
                        limit = int'(cfg_words_copy);
                        if (limit == 0) limit = 1;
                        if (limit > MAX_TRACK_WORDS) limit = MAX_TRACK_WORDS;
                        r.data_word   = val;
                        r.word_index  = long_cnt;
                        r.sync_offset = sync_pos;
                        if (int'(long_cnt) + 1 >= limit) begin
                            r.last    = 1'b1;
                            r.status  = (csum_left == 0) ? ST_GOOD : ST_BAD;
                            trk_phase = (csum_left == 0) ? TRK_IDLE : TRK_HUNT;
                            long_cnt  = '0;
                        end else begin
                            r.last   = 1'b0;
                            r.status = ST_DATA;
                            long_cnt = long_cnt + INDEX_W'(1);
                        end
                        expected_track_results.push_back(r);
                    end
                end
                default: ;
            endcase
        end
    endtask

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    // Monitor: checks every result transaction, then predicts from every input transaction.
    always @(posedge i_clk) begin : result_monitor
        t_result      want;
        stream_item_t it;
        in_taken  <= in_if.valid && in_if.ready;
        out_taken <= out_if.valid && out_if.ready;
        if (i_rst_n) begin
            if (out_if.valid && out_if.ready) begin
                results_checked++;
                if (expected_track_results.size() == 0) begin
                    $display("%0t ns: result with none expected, actual data_word %h status %0d",
                             $time, out_if.data_word, out_if.status);
                    mismatches++;
                end else begin
                    want = expected_track_results.pop_front();
                    check_field("data_word", want.data_word, out_if.data_word);
                    check_field("word_index", 32'(want.word_index), 32'(out_if.word_index));
                    check_field("last", 32'(want.last), 32'(out_if.last));
                    check_field("status", 32'(want.status), 32'(out_if.status));
                    check_field("sync_offset", want.sync_offset, out_if.sync_offset);
                end
            end
            if (in_if.valid && in_if.ready) begin
                it.kind    = in_if.kind;
                it.raw_bit = in_if.raw_bit;
                track_decode_step(it);
                items_taken++;
            end
        end
    end

    // Watchdog: ends the run when no transaction moves for too long.
    always @(posedge i_clk) begin : stall_watchdog
        int quiet;
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
            quiet = 0;
        else
            quiet++;
        if (quiet >= STALL_LIMIT) begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    // Sender: offers queued items with a random gap after each one, calm stretches and src_nogap runs without gaps.
    always @(negedge i_clk) begin : stream_driver
        stream_item_t it;
        if (!drv_valid || in_taken) begin
            if (src_wait > 0) begin
                drv_valid <= 1'b0;
                src_wait--;
            end else if (bit_stream_q.size() != 0) begin
                it = bit_stream_q.pop_front();
                drv_valid <= 1'b1;
                drv_kind  <= it.kind;
                drv_bit   <= it.raw_bit;
                if ($urandom_range(0, 39) == 0) src_calm = !src_calm;
                src_wait = (src_calm || src_nogap) ? 0 : $urandom_range(0, 14);
            end else begin
                drv_valid <= 1'b0;
            end
        end
    end

    // Receiver: random hold-off after each result, plus long hold-offs on request.
    always @(negedge i_clk) begin : result_sink
        if (i_rst_n) begin
            if (hold_requests != hold_served) begin
                hold_served = hold_requests;
                sink_wait   = LONG_HOLD;
            end else if (out_taken) begin
                if ($urandom_range(0, 39) == 0) sink_calm = !sink_calm;
                sink_wait = sink_calm ? 0 : $urandom_range(0, 14);
            end
            if (sink_wait > 0) begin
                sink_ready <= 1'b0;
                sink_wait--;
            end else begin
                sink_ready <= 1'b1;
            end
        end
    end

    // Stimulus helpers.
    task automatic push_item(input logic kind, input logic raw_bit);
        stream_item_t it;
        it.kind    = kind;
        it.raw_bit = raw_bit;
        bit_stream_q.push_back(it);
        items_pushed++;
    endtask

    task automatic push_eos();
        push_item(KIND_EOS, 1'($urandom_range(0, 1)));
    endtask

    task automatic push_raw(input logic [63:0] bits, input int count);
        for (int i = count - 1; i >= 0; i--)
            push_item(KIND_BIT, bits[i]);
    endtask

    task automatic push_noise(input int count);
        for (int i = 0; i < count; i++)
            push_item(KIND_BIT, 1'($urandom_range(0, 1)));
    endtask

    // Encodes one long as odd cells then even cells; clock cells are random.
    task automatic push_long(input logic [DATA_W-1:0] data);
        logic [RAW_W-1:0] raw;
        raw = {$urandom, $urandom};
        for (int k = 0; k < 16; k++) begin
            raw[2*k+32] = data[2*k+1];
            raw[2*k]    = data[2*k];
        end
        push_raw(raw, 64);
    endtask

    function automatic logic [DATA_W-1:0] rand_long();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return $urandom;
        endcase
    endfunction

    // One track: optional sync word, checksum long, then the data longs.
    task automatic push_track(input int n_data, input bit corrupt, input bit with_sync);
        logic [DATA_W-1:0] longs[$];
        logic [DATA_W-1:0] total;
        total = '0;
        for (int i = 0; i < n_data; i++) begin
            longs.push_back(rand_long());
            total = total + longs[i];
        end
        if (corrupt) total = total + $urandom_range(1, 32'hFFFF_FFFF);
        if (with_sync) push_raw(RAW_W'(cfg_sync_copy), SYNC_W);
        push_long(total);
        foreach (longs[i]) push_long(longs[i]);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
        @(negedge i_clk);
        cfg_we <= 1'b0;
        if (idx == CFG_SYNC_PATTERN)
            cfg_sync_copy = value;
        else
            cfg_words_copy = value[TRACK_WORDS_W-1:0];
    endtask

    // Waits until every item is taken and every result checked, then lets the pipe drain.
    task automatic wait_idle();
        while (items_taken != items_pushed || expected_track_results.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // One random phase: new settings, then well-formed tracks mixed with noise and cuts.
    task automatic random_phase();
        int pick;
        int words;
        int n;
        pick = $urandom_range(0, 19);
        if (pick < 3)
            words = 0;
        else if (pick < 16)
            words = $urandom_range(1, 4);
        else
            words = $urandom_range(5, 8);
        write_reg(CFG_TRACK_WORDS, 16'(words));
        pick = $urandom_range(0, 9);
        if (pick < 3)
            write_reg(CFG_SYNC_PATTERN, 16'h8915);
        else if (pick < 5)
            write_reg(CFG_SYNC_PATTERN, 16'h4489);
        else
            write_reg(CFG_SYNC_PATTERN, 16'($urandom_range(0, 16'hFFFF)));
        n = (words == 0) ? 1 : words;
        repeat ($urandom_range(1, 3)) begin
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                push_noise($urandom_range(0, 20));
                push_track(n, $urandom_range(0, 3) == 0, 1'b1);
                if ($urandom_range(0, 1) == 1) push_noise($urandom_range(0, 30));
            end else if (pick < 75) begin
                // Track cut short by end of stream.
                push_raw(RAW_W'(cfg_sync_copy), SYNC_W);
                push_noise($urandom_range(1, 64 * (n + 1) - 1));
                push_eos();
            end else if (pick < 90) begin
                push_noise($urandom_range(10, 80));
            end else begin
                push_eos();
            end
        end
        push_eos();
        wait_idle();
    endtask

    // Main sequence.
    initial begin
        int phase_cnt;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // End of stream while hunting, with reset settings.
        push_eos();
        push_eos();
        wait_idle();

        // Good track, raw bits while idle, then end of stream after a pass.
        write_reg(CFG_TRACK_WORDS, 16'd1);
        push_noise(5);
        push_track(1, 1'b0, 1'b1);
        push_noise(40);
        push_eos();
        wait_idle();

        // Bad checksum resumes the hunt; the next track passes.
        write_reg(CFG_TRACK_WORDS, 16'd2);
        push_track(2, 1'b1, 1'b1);
        push_track(2, 1'b0, 1'b1);
        push_eos();
        wait_idle();

        // All-zero sync matches on the first bit, so the offset wraps; zero length is one long.
        write_reg(CFG_SYNC_PATTERN, 16'h0000);
        write_reg(CFG_TRACK_WORDS, 16'd0);
        push_item(KIND_BIT, 1'b0);
        push_track(1, 1'b0, 1'b0);
        push_eos();
        wait_idle();

        // All-ones sync and data longs at the extremes.
        write_reg(CFG_SYNC_PATTERN, 16'hFFFF);
        write_reg(CFG_TRACK_WORDS, 16'd2);
        push_raw(RAW_W'(16'hFFFF), SYNC_W);
        push_long(32'hFFFF_FFFF);
        push_long(32'hFFFF_FFFF);
        push_long(32'h0000_0000);
        push_eos();
        wait_idle();

        // End of stream while gathering the checksum, then while gathering data.
        write_reg(CFG_SYNC_PATTERN, 16'h8915);
        push_raw(RAW_W'(16'h8915), SYNC_W);
        push_noise(30);
        push_eos();
        push_raw(RAW_W'(16'h8915), SYNC_W);
        push_noise(64 + 64 + 10);
        push_eos();
        wait_idle();

        // Receiver holds off while the sender keeps offering, so the result queue fills.
        write_reg(CFG_TRACK_WORDS, 16'd1);
        src_nogap = 1'b1;
        hold_requests++;
        repeat (24) push_eos();
        push_track(1, 1'b0, 1'b1);
        push_eos();
        push_track(1, 1'b1, 1'b1);
        push_eos();
        wait_idle();

        // A length above the cap, cut short by end of stream.
        write_reg(CFG_TRACK_WORDS, 16'd8191);
        push_raw(RAW_W'(16'h8915), SYNC_W);
        push_noise(64 * 2 + 5);
        push_eos();
        wait_idle();
        src_nogap = 1'b0;

        // Random phases until enough items have gone through.
        phase_cnt = 0;
        while (items_pushed < TOTAL_ITEMS && phase_cnt < 200) begin
            random_phase();
            phase_cnt++;
        end

        wait_idle();
        if (mismatches == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
